>>> rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PAID_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PAID_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> rtl/paid_pkg.sv
package paid_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 3;
    // wide enough for positions and counts plus one without overflow
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT  = 2'd0,
        REQ_DEL_POS = 2'd1,
        REQ_DEL_VAL = 2'd2,
        REQ_READ    = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_BADPOS   = 3'd4
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture request and range checks
        logic start;   // arm the shift sweep
        logic sweep;   // run the shift sweep
        logic rd;      // read the addressed entry
        logic put;     // write the inserted value
        logic finish;  // commit count and load the result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_req req;
        logic pre_ok;
        logic need_sweep;
        logic sweep_done;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/paid_if.sv
interface paid_req_if;
    logic                               valid;
    logic                               ready;
    logic [paid_pkg::REQ_W-1:0]         req_type;
    logic [paid_pkg::POS_W-1:0]         position;
    logic signed [paid_pkg::DATA_W-1:0] item_value;

    modport source (output valid, req_type, position, item_value, input ready);
    modport sink   (input valid, req_type, position, item_value, output ready);
endinterface

interface paid_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [paid_pkg::STAT_W-1:0]        status;
    logic [paid_pkg::POS_W-1:0]         count_after;
    logic signed [paid_pkg::DATA_W-1:0] read_value;
    logic [paid_pkg::POS_W-1:0]         found_position;

    modport source (output valid, status, count_after, read_value, found_position,
                    input ready);
    modport sink   (input valid, status, count_after, read_value, found_position,
                    output ready);
endinterface

>>> rtl/positional_array_insert_delete_top.sv
// Ordered store of up to DEPTH signed 32-bit entries, kept packed at positions
// 1..count, with insert at a position, delete at a position, delete of the
// first entry equal to a value, and read at a position. Every request yields
// exactly one result with a status, the count after the request, the value
// read and the position removed by a value delete. One request is in work at
// a time; i_req.ready is high while the block is idle, and it takes the next
// request even while the previous result still waits in the result register.
// The entries live in a single-port-write, single-port-read RAM, so shifting
// runs one entry per cycle and sets the latency. A refused request, a read,
// an append and a delete of the last entry need no shift; a delete by value
// scans and shifts in one pass. The RAM needs no clearing after reset: only
// positions 1..count are ever read.
module positional_array_insert_delete_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    paid_req_if.sink   i_req,
    paid_rsp_if.source o_rsp
);

    paid_pkg::t_cmd w_cmd;
    paid_pkg::t_sts w_sts;

    // sequencer: accept, dispatch, sweep, commit
    paid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // entry RAM, count, shift sweep and result register
    paid_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_req_type       (i_req.req_type),
        .i_position       (i_req.position),
        .i_item_value     (i_req.item_value),
        .o_rsp_valid      (o_rsp.valid),
        .i_rsp_ready      (o_rsp.ready),
        .o_status         (o_rsp.status),
        .o_count_after    (o_rsp.count_after),
        .o_read_value     (o_rsp.read_value),
        .o_found_position (o_rsp.found_position)
    );

endmodule

>>> rtl/paid_ram.sv
module paid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/paid_ctrl.sv
module paid_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  paid_pkg::t_sts  i_sts,
    output paid_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SHIFT,
        S_PUT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!i_sts.pre_ok) begin
                    n_state = S_DONE;
                end else if (i_sts.req == paid_pkg::REQ_READ) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_DONE;
                end else if (i_sts.need_sweep) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SHIFT;
                end else if (i_sts.req == paid_pkg::REQ_INSERT) begin
                    n_state = S_PUT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_done) begin
                    n_state = (i_sts.req == paid_pkg::REQ_INSERT) ? S_PUT : S_DONE;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/paid_dp.sv
module paid_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  paid_pkg::t_cmd                     i_cmd,
    output paid_pkg::t_sts                     o_sts,
    input  logic [paid_pkg::REQ_W-1:0]         i_req_type,
    input  logic [paid_pkg::POS_W-1:0]         i_position,
    input  logic signed [paid_pkg::DATA_W-1:0] i_item_value,
    output logic                               o_rsp_valid,
    input  logic                               i_rsp_ready,
    output logic [paid_pkg::STAT_W-1:0]        o_status,
    output logic [paid_pkg::POS_W-1:0]         o_count_after,
    output logic signed [paid_pkg::DATA_W-1:0] o_read_value,
    output logic [paid_pkg::POS_W-1:0]         o_found_position
);

    // control registers
    logic [paid_pkg::CNT_W-1:0]  r_count,   n_count;
    logic                        r_rd_act,  n_rd_act;
    logic                        r_pend,    n_pend;
    logic                        r_hit,     n_hit;
    logic                        r_out_vld, n_out_vld;
    // payload registers
    paid_pkg::t_req              r_req,     n_req;
    paid_pkg::t_status           r_pre,     n_pre;
    logic                        r_need,    n_need;
    logic [paid_pkg::IDX_W-1:0]  r_pos_idx, n_pos_idx;
    logic [paid_pkg::DATA_W-1:0] r_val,     n_val;
    logic [paid_pkg::IDX_W-1:0]  r_addr,    n_addr;
    logic [paid_pkg::IDX_W-1:0]  r_last,    n_last;
    logic [paid_pkg::IDX_W-1:0]  r_pend_addr, n_pend_addr;
    logic [paid_pkg::IDX_W-1:0]  r_hit_idx, n_hit_idx;
    logic [paid_pkg::STAT_W-1:0] r_o_stat,  n_o_stat;
    logic [paid_pkg::POS_W-1:0]  r_o_cnt,   n_o_cnt;
    logic [paid_pkg::DATA_W-1:0] r_o_rd,    n_o_rd;
    logic [paid_pkg::POS_W-1:0]  r_o_found, n_o_found;

    logic [paid_pkg::CMP_W-1:0]  w_pos_x;
    logic [paid_pkg::CMP_W-1:0]  w_cnt_x;
    logic [paid_pkg::CMP_W-1:0]  w_pos_m1;
    logic [paid_pkg::CMP_W-1:0]  w_cnt_m1;
    logic [paid_pkg::CMP_W-1:0]  w_cnt_new;
    logic [paid_pkg::CMP_W-1:0]  w_found_x;
    logic                        w_pos_zero;
    paid_pkg::t_req              w_req_in;
    paid_pkg::t_status           w_pre_in;
    logic                        w_need_in;
    paid_pkg::t_status           w_final;

    logic                        w_wr_en;
    logic [paid_pkg::IDX_W-1:0]  w_wr_addr;
    logic [paid_pkg::DATA_W-1:0] w_wr_data;
    logic                        w_rd_en;
    logic [paid_pkg::IDX_W-1:0]  w_rd_addr;
    logic [paid_pkg::DATA_W-1:0] w_rd_data;

    paid_ram #(
        .WIDTH (paid_pkg::DATA_W),
        .DEPTH (paid_pkg::DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // range checks on the incoming request
    always_comb begin
        w_req_in   = paid_pkg::t_req'(i_req_type);
        w_pos_x    = (paid_pkg::CMP_W)'(i_position);
        w_cnt_x    = (paid_pkg::CMP_W)'(r_count);
        w_pos_zero = (i_position == '0);
        w_pre_in   = paid_pkg::ST_OK;
        w_need_in  = 1'b0;
        case (w_req_in)
            paid_pkg::REQ_INSERT: begin
                if (w_cnt_x == (paid_pkg::CMP_W)'(paid_pkg::DEPTH)) begin
                    w_pre_in = paid_pkg::ST_FULL;
                end else if (w_pos_zero ||
                             w_pos_x > w_cnt_x + (paid_pkg::CMP_W)'(1)) begin
                    w_pre_in = paid_pkg::ST_BADPOS;
                end
                w_need_in = (w_pos_x <= w_cnt_x);
            end
            paid_pkg::REQ_DEL_POS: begin
                if (r_count == '0) begin
                    w_pre_in = paid_pkg::ST_EMPTY;
                end else if (w_pos_zero || w_pos_x > w_cnt_x) begin
                    w_pre_in = paid_pkg::ST_BADPOS;
                end
                w_need_in = (w_pos_x < w_cnt_x);
            end
            paid_pkg::REQ_DEL_VAL: begin
                if (r_count == '0) begin
                    w_pre_in = paid_pkg::ST_EMPTY;
                end
                w_need_in = 1'b1;
            end
            paid_pkg::REQ_READ: begin
                if (w_pos_zero || w_pos_x > w_cnt_x) begin
                    w_pre_in = paid_pkg::ST_BADPOS;
                end
            end
            default: begin
                w_pre_in = paid_pkg::ST_BADPOS;
            end
        endcase
    end

    assign w_pos_m1 = w_pos_x - (paid_pkg::CMP_W)'(1);
    assign w_cnt_m1 = w_cnt_x - (paid_pkg::CMP_W)'(1);

    // result of the request being closed out
    always_comb begin
        if (r_pre != paid_pkg::ST_OK) begin
            w_final = r_pre;
        end else if (r_req == paid_pkg::REQ_DEL_VAL && !r_hit) begin
            w_final = paid_pkg::ST_NOTFOUND;
        end else begin
            w_final = paid_pkg::ST_OK;
        end
    end

    always_comb begin
        w_cnt_new = (paid_pkg::CMP_W)'(r_count);
        if (w_final == paid_pkg::ST_OK) begin
            if (r_req == paid_pkg::REQ_INSERT) begin
                w_cnt_new = (paid_pkg::CMP_W)'(r_count) + (paid_pkg::CMP_W)'(1);
            end else if (r_req == paid_pkg::REQ_DEL_POS ||
                         r_req == paid_pkg::REQ_DEL_VAL) begin
                w_cnt_new = (paid_pkg::CMP_W)'(r_count) - (paid_pkg::CMP_W)'(1);
            end
        end
    end

    assign w_found_x = (paid_pkg::CMP_W)'(r_hit_idx) + (paid_pkg::CMP_W)'(1);

    // memory ports: sweep read, shifted write-back, final insert write
    always_comb begin
        w_rd_en   = (i_cmd.sweep && r_rd_act) || i_cmd.rd;
        w_rd_addr = i_cmd.rd ? r_pos_idx : r_addr;
        w_wr_en   = 1'b0;
        w_wr_addr = r_pos_idx;
        w_wr_data = r_val;
        if (i_cmd.put) begin
            w_wr_en = 1'b1;
        end else if (i_cmd.sweep && r_pend) begin
            w_wr_data = w_rd_data;
            if (r_req == paid_pkg::REQ_INSERT) begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_pend_addr + (paid_pkg::IDX_W)'(1);
            end else if (r_hit) begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_pend_addr - (paid_pkg::IDX_W)'(1);
            end
        end
    end

    always_comb begin
        n_count     = r_count;
        n_rd_act    = r_rd_act;
        n_pend      = r_pend;
        n_hit       = r_hit;
        n_out_vld   = r_out_vld;
        n_req       = r_req;
        n_pre       = r_pre;
        n_need      = r_need;
        n_pos_idx   = r_pos_idx;
        n_val       = r_val;
        n_addr      = r_addr;
        n_last      = r_last;
        n_pend_addr = r_pend_addr;
        n_hit_idx   = r_hit_idx;
        n_o_stat    = r_o_stat;
        n_o_cnt     = r_o_cnt;
        n_o_rd      = r_o_rd;
        n_o_found   = r_o_found;

        if (i_cmd.load) begin
            n_req     = w_req_in;
            n_pre     = w_pre_in;
            n_need    = w_need_in;
            n_pos_idx = w_pos_m1[paid_pkg::IDX_W-1:0];
            n_val     = $unsigned(i_item_value);
        end

        if (i_cmd.start) begin
            n_rd_act  = 1'b1;
            n_pend    = 1'b0;
            n_hit     = (r_req == paid_pkg::REQ_DEL_POS);
            n_hit_idx = r_pos_idx;
            case (r_req)
                paid_pkg::REQ_INSERT: begin
                    n_addr = w_cnt_m1[paid_pkg::IDX_W-1:0];
                    n_last = r_pos_idx;
                end
                paid_pkg::REQ_DEL_POS: begin
                    n_addr = r_pos_idx + (paid_pkg::IDX_W)'(1);
                    n_last = w_cnt_m1[paid_pkg::IDX_W-1:0];
                end
                default: begin
                    n_addr = '0;
                    n_last = w_cnt_m1[paid_pkg::IDX_W-1:0];
                end
            endcase
        end

        if (i_cmd.sweep) begin
            // read stage: walk toward the last address
            n_pend      = r_rd_act;
            n_pend_addr = r_addr;
            if (r_rd_act) begin
                if (r_addr == r_last) begin
                    n_rd_act = 1'b0;
                end else if (r_req == paid_pkg::REQ_INSERT) begin
                    n_addr = r_addr - (paid_pkg::IDX_W)'(1);
                end else begin
                    n_addr = r_addr + (paid_pkg::IDX_W)'(1);
                end
            end
            // compare stage: first match opens the hole
            if (r_pend && r_req == paid_pkg::REQ_DEL_VAL && !r_hit &&
                w_rd_data == r_val) begin
                n_hit     = 1'b1;
                n_hit_idx = r_pend_addr;
            end
        end

        if (i_cmd.finish) begin
            n_count   = w_cnt_new[paid_pkg::CNT_W-1:0];
            n_out_vld = 1'b1;
            n_o_stat  = w_final;
            n_o_cnt   = w_cnt_new[paid_pkg::POS_W-1:0];
            n_o_rd    = (r_req == paid_pkg::REQ_READ && w_final == paid_pkg::ST_OK)
                        ? w_rd_data : '0;
            n_o_found = (r_req == paid_pkg::REQ_DEL_VAL && w_final == paid_pkg::ST_OK)
                        ? w_found_x[paid_pkg::POS_W-1:0] : '0;
        end else if (i_rsp_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd_act  <= 1'b0;
            r_pend    <= 1'b0;
            r_hit     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_rd_act  <= n_rd_act;
            r_pend    <= n_pend;
            r_hit     <= n_hit;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_pre       <= n_pre;
        r_need      <= n_need;
        r_pos_idx   <= n_pos_idx;
        r_val       <= n_val;
        r_addr      <= n_addr;
        r_last      <= n_last;
        r_pend_addr <= n_pend_addr;
        r_hit_idx   <= n_hit_idx;
        r_o_stat    <= n_o_stat;
        r_o_cnt     <= n_o_cnt;
        r_o_rd      <= n_o_rd;
        r_o_found   <= n_o_found;
    end

    assign o_sts.req        = r_req;
    assign o_sts.pre_ok     = (r_pre == paid_pkg::ST_OK);
    assign o_sts.need_sweep = r_need;
    assign o_sts.sweep_done = !r_rd_act && !r_pend;
    assign o_sts.out_free   = !r_out_vld || i_rsp_ready;

    assign o_rsp_valid      = r_out_vld;
    assign o_status         = r_o_stat;
    assign o_count_after    = r_o_cnt;
    assign o_read_value     = $signed(r_o_rd);
    assign o_found_position = r_o_found;

endmodule

>>> rtl/paid_checker.sv
`include "assert_macros.svh"

module paid_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_rsp_valid,
    input logic                               i_rsp_ready,
    input logic [paid_pkg::STAT_W-1:0]        i_status,
    input logic [paid_pkg::POS_W-1:0]         i_count_after,
    input logic signed [paid_pkg::DATA_W-1:0] i_read_value,
    input logic [paid_pkg::POS_W-1:0]         i_found_position
);

    logic [paid_pkg::POS_W-1:0] r_last_cnt;
    logic [paid_pkg::POS_W-1:0] w_cnt_up;
    logic [paid_pkg::POS_W-1:0] w_cnt_dn;
    logic [paid_pkg::POS_W:0]   w_cnt_lim;

    // track the count reported by the last delivered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_cnt <= '0;
        end else if (i_rsp_valid && i_rsp_ready) begin
            r_last_cnt <= i_count_after;
        end
    end

    assign w_cnt_up  = r_last_cnt + (paid_pkg::POS_W)'(1);
    assign w_cnt_dn  = r_last_cnt - (paid_pkg::POS_W)'(1);
    assign w_cnt_lim = {1'b0, i_count_after} + (paid_pkg::POS_W + 1)'(1);

    `PAID_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_status) && $stable(i_count_after), "result dropped or changed while stalled")

    `PAID_ASSERT_IMP(a_cnt_step, i_clk, i_rst_n, i_rsp_valid, i_count_after == r_last_cnt || i_count_after == w_cnt_up || i_count_after == w_cnt_dn, "count moved by more than one entry")

    `PAID_ASSERT_IMP(a_refused_keeps, i_clk, i_rst_n, i_rsp_valid && i_status != paid_pkg::ST_OK, i_count_after == r_last_cnt && i_read_value == '0 && i_found_position == '0, "refused request changed the store")

    `PAID_ASSERT_IMP(a_found_range, i_clk, i_rst_n, i_rsp_valid && i_found_position != '0, {1'b0, i_found_position} <= w_cnt_lim && i_count_after == w_cnt_dn, "removed position outside the stored range")

endmodule

bind positional_array_insert_delete_top paid_checker u_paid_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_status         (o_rsp.status),
    .i_count_after    (o_rsp.count_after),
    .i_read_value     (o_rsp.read_value),
    .i_found_position (o_rsp.found_position)
);

>>> tb/positional_array_insert_delete_top_tb.sv
`timescale 1ns / 100ps

module positional_array_insert_delete_top_tb;
    import paid_pkg::*;

    // Generous ceiling on the whole run, in nanoseconds.
    localparam int RUN_LIMIT_NS  = 4_000_000;
    // Cycles to linger after the last result; covers the longest shift.
    localparam int SETTLE_CYCLES = 80;
    localparam int REPORT_MAX    = 10;

    // Expected fields of one result.
    typedef struct {
        t_status                   status;
        logic [POS_W-1:0]          count_after;
        logic signed [DATA_W-1:0]  read_value;
        logic [POS_W-1:0]          found_position;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;

    paid_req_if req_bus ();
    paid_rsp_if rsp_bus ();

    positional_array_insert_delete_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // Shadow copy of the ordered store, kept packed at indexes 0..shadow_count-1.
    logic signed [DATA_W-1:0] shadow_entries [DEPTH];
    int unsigned              shadow_count;

    // Results still owed by the block, oldest first.
    t_outcome    pending_outcomes [$];
    int unsigned mismatch_count;

    // Idle percentages for the current phase.
    int unsigned sender_idle_pct;
    int unsigned recv_stall_pct;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Close the shadow store over the hole at idx and shrink the count.
    function automatic void drop_entry(int unsigned idx);
        int unsigned k;
        for (k = idx; k + 1 < shadow_count; k++)
            shadow_entries[k] = shadow_entries[k + 1];
        shadow_count--;
    endfunction

    // Apply one request to the shadow store and return the result it must produce.
    function automatic t_outcome apply_request(t_req kind, logic [POS_W-1:0] pos,
                                               logic signed [DATA_W-1:0] val);
        t_outcome    res;
        int unsigned p;
        int unsigned k;
        int          hit;
        p = pos;
        hit = -1;
        res.status = ST_OK;
        res.read_value = '0;
        res.found_position = '0;
        case (kind)
            REQ_INSERT: begin
                // Full is checked ahead of the position.
                if (shadow_count >= DEPTH)
                    res.status = ST_FULL;
                else if (p < 1 || p > shadow_count + 1)
                    res.status = ST_BADPOS;
                else begin
                    for (k = shadow_count; k > p - 1; k--)
                        shadow_entries[k] = shadow_entries[k - 1];
                    shadow_entries[p - 1] = val;
                    shadow_count++;
                end
            end
            REQ_DEL_POS: begin
                if (shadow_count == 0)
                    res.status = ST_EMPTY;
                else if (p < 1 || p > shadow_count)
                    res.status = ST_BADPOS;
                else
                    drop_entry(p - 1);
            end
            REQ_DEL_VAL: begin
                if (shadow_count == 0)
                    res.status = ST_EMPTY;
                else begin
                    // First match wins.
                    for (k = 0; k < shadow_count && hit < 0; k++)
                        if (shadow_entries[k] == val)
                            hit = k;
                    if (hit < 0)
                        res.status = ST_NOTFOUND;
                    else begin
                        res.found_position = POS_W'(hit + 1);
                        drop_entry(hit);
                    end
                end
            end
            default: begin
                if (p < 1 || p > shadow_count)
                    res.status = ST_BADPOS;
                else
                    res.read_value = shadow_entries[p - 1];
            end
        endcase
        res.count_after = POS_W'(shadow_count);
        return res;
    endfunction

    function automatic void note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // Drive one request, hold it until the block takes it, then log its outcome.
    // Valid stays high on return so back-to-back requests follow without a gap.
    task automatic send_request(t_req kind, logic [POS_W-1:0] pos,
                                logic signed [DATA_W-1:0] val);
        while ($urandom_range(99) < sender_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= kind;
        req_bus.position   <= pos;
        req_bus.item_value <= val;
        do
            @(posedge i_clk);
        while (!req_bus.ready);
        pending_outcomes.push_back(apply_request(kind, pos, val));
    endtask

    // Drop valid and hold off until every owed result has been taken.
    task automatic wait_for_drain();
        req_bus.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    // Extremes of every field, every request kind and every refusal but a full store, from empty.
    task automatic test_directed();
        send_request(REQ_READ,    7'd1,   32'sd0);          // read on empty: bad position
        send_request(REQ_DEL_POS, 7'd1,   32'sd0);          // delete on empty
        send_request(REQ_DEL_VAL, 7'd0,   32'sd0);          // value delete on empty
        send_request(REQ_INSERT,  7'd0,   32'sd5);          // position zero
        send_request(REQ_INSERT,  7'd2,   32'sd5);          // beyond count + 1
        send_request(REQ_INSERT,  7'd1,   32'h8000_0000);   // most negative value
        send_request(REQ_INSERT,  7'd2,   32'h7FFF_FFFF);   // append most positive
        send_request(REQ_INSERT,  7'd1,   -32'sd1);         // insert at head
        send_request(REQ_INSERT,  7'd3,   32'sd100);        // insert in the middle
        send_request(REQ_INSERT,  7'd5,   -32'sd1);         // append a duplicate
        send_request(REQ_INSERT,  7'd127, 32'sd1);          // all-ones position
        send_request(REQ_READ,    7'd0,   32'sd0);
        send_request(REQ_READ,    7'd127, 32'sd0);
        send_request(REQ_READ,    7'd6,   32'sd0);          // one past count
        send_request(REQ_READ,    7'd1,   32'sd0);
        send_request(REQ_READ,    7'd5,   32'sd0);
        send_request(REQ_DEL_VAL, 7'd99,  -32'sd1);         // removes the first -1 only
        send_request(REQ_DEL_VAL, 7'd0,   32'sd0);          // absent value
        send_request(REQ_DEL_POS, 7'd0,   32'sd0);
        send_request(REQ_DEL_POS, 7'd5,   32'sd0);          // one past count
        send_request(REQ_DEL_POS, 7'd4,   32'sd0);          // last entry
        send_request(REQ_DEL_POS, 7'd1,   32'sd0);          // head entry
        send_request(REQ_DEL_VAL, 7'd0,   32'h7FFF_FFFF);
        send_request(REQ_DEL_VAL, 7'd0,   32'sd100);        // leaves the store empty
        send_request(REQ_READ,    7'd1,   32'sd0);
    endtask

    // Load the store to capacity by appends, then exercise the full-store refusals
    // and the longest shifts.
    task automatic test_full_store();
        while (shadow_count < DEPTH)
            send_request(REQ_INSERT, POS_W'(shadow_count + 1), $urandom);
        send_request(REQ_INSERT,  7'd1,   32'sd7);          // full beats a good position
        send_request(REQ_INSERT,  7'd0,   32'sd7);          // full beats a bad position
        send_request(REQ_INSERT,  7'd127, 32'sd7);
        send_request(REQ_READ,    POS_W'(DEPTH),     32'sd0);
        send_request(REQ_READ,    POS_W'(DEPTH + 1), 32'sd0);
        send_request(REQ_DEL_POS, 7'd1,   32'sd0);          // shift the whole store down
        send_request(REQ_INSERT,  7'd1,   -32'sd1);         // and back up
        send_request(REQ_DEL_VAL, 7'd0,   shadow_entries[DEPTH - 1]);
        send_request(REQ_DEL_POS, POS_W'(DEPTH + 1), 32'sd0);
        // Let the block run dry before anything else goes in.
        wait_for_drain();
    endtask

    // One random request, biased toward legal positions and values that hit.
    task automatic send_random_request(int unsigned grow_pct);
        int unsigned              roll;
        int unsigned              n;
        t_req                     kind;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        n = shadow_count;
        roll = $urandom_range(99);
        if (roll < grow_pct)
            kind = REQ_INSERT;
        else begin
            case ((roll - grow_pct) % 3)
                0:       kind = REQ_DEL_POS;
                1:       kind = REQ_DEL_VAL;
                default: kind = REQ_READ;
            endcase
        end

        if ($urandom_range(99) < 12)
            pos = POS_W'($urandom_range(127));
        else if (kind == REQ_INSERT)
            pos = POS_W'($urandom_range(n + 1, 1));
        else if (n > 0)
            pos = POS_W'($urandom_range(n, 1));
        else
            pos = POS_W'($urandom_range(127));

        // Small values make duplicates, so first-match removal gets exercised.
        if (kind == REQ_DEL_VAL && n > 0 && $urandom_range(99) < 70)
            val = shadow_entries[$urandom_range(n - 1)];
        else if ($urandom_range(99) < 30)
            val = int'($urandom_range(6)) - 3;
        else
            val = $urandom;

        send_request(kind, pos, val);
    endtask

    // Random traffic under one idling pattern; alternate fill and drain stretches
    // so the count sweeps between empty and full.
    task automatic test_random_mix(int unsigned idle_pct, int unsigned stall_pct,
                                   int unsigned items);
        int unsigned i;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        for (i = 0; i < items; i++)
            send_random_request(((i / 90) % 2 == 0) ? 60 : 15);
        wait_for_drain();
    endtask

    // Receiver: randomly stall the result channel.
    initial begin
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare every taken result with the oldest outstanding expectation.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_outcomes.size() == 0)
                note_mismatch($sformatf("result with none outstanding: st=%0d cnt=%0d",
                                        rsp_bus.status, rsp_bus.count_after));
            else begin
                want = pending_outcomes.pop_front();
                if (rsp_bus.status !== want.status
                        || rsp_bus.count_after !== want.count_after
                        || rsp_bus.read_value !== want.read_value
                        || rsp_bus.found_position !== want.found_position)
                    note_mismatch($sformatf(
                        "exp st=%0d cnt=%0d rd=%0d fnd=%0d, got st=%0d cnt=%0d rd=%0d fnd=%0d",
                        want.status, want.count_after, want.read_value,
                        want.found_position, rsp_bus.status, rsp_bus.count_after,
                        rsp_bus.read_value, rsp_bus.found_position));
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        shadow_count    = 0;
        mismatch_count  = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        i_rst_n            <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.req_type   <= REQ_INSERT;
        req_bus.position   <= '0;
        req_bus.item_value <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_store();
        test_random_mix(0,  0,  350);
        test_random_mix(65, 0,  350);
        test_random_mix(0,  65, 350);
        test_random_mix(36, 36, 350);

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_outcomes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> positional_array_insert_delete_top.f
+incdir+rtl
rtl/paid_pkg.sv
rtl/paid_if.sv
rtl/paid_ram.sv
rtl/paid_ctrl.sv
rtl/paid_dp.sv
rtl/positional_array_insert_delete_top.sv
rtl/paid_checker.sv
tb/positional_array_insert_delete_top_tb.sv
